FILE: rtl/bmt_pkg.sv
package bmt_pkg;

  localparam int unsigned TABLE_ENTRIES = 1048576;
  localparam int unsigned TABLE_AW      = $clog2(TABLE_ENTRIES);
  localparam int unsigned LIST_ENTRIES  = 256;
  localparam int unsigned LIST_AW       = $clog2(LIST_ENTRIES);
  localparam int unsigned LIST_CW       = LIST_AW + 1;
  localparam int unsigned SQ_W          = 6;
  localparam int unsigned FROM_LSB      = 12;
  localparam int unsigned TO_LSB        = 18;

  typedef enum logic [1:0] {
    REQ_STORE  = 2'd0,
    REQ_PROBE  = 2'd1,
    REQ_APPEND = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_STORED       = 3'd0,
    ST_SKIPPED      = 3'd1,
    ST_MISS         = 3'd2,
    ST_HIT_ABSENT   = 3'd3,
    ST_HIT_FRONT    = 3'd4,
    ST_APPENDED     = 3'd5,
    ST_FULL         = 3'd6,
    ST_CLEAR_OR_BAD = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    TOP_NONE,
    TOP_RD,
    TOP_WR,
    TOP_CLR
  } tab_op_e;

  typedef enum logic [3:0] {
    LOP_NONE,
    LOP_STORE_RD,
    LOP_SCAN_FIRST,
    LOP_SCAN_NEXT,
    LOP_SHIFT_START,
    LOP_SHIFT_STEP,
    LOP_FRONT,
    LOP_APPEND,
    LOP_CLEAR
  } list_op_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [19:0] table_index;
    logic [5:0]  search_depth;
    logic [7:0]  move_index;
    logic [31:0] move_word;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] found_from;
    logic [5:0] found_to;
    logic [8:0] list_length;
  } rsp_t;

  typedef struct packed {
    logic            valid;
    logic [5:0]      depth;
    logic [SQ_W-1:0] from_sq;
    logic [SQ_W-1:0] to_sq;
  } entry_t;

  typedef struct packed {
    logic     load_req;
    tab_op_e  tab_op;
    list_op_e list_op;
    logic     latch_entry;
    logic     load_out;
    status_e  out_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       bound_bad;
    logic       tab_valid;
    logic       depth_ok;
    logic       list_full;
    logic       list_empty;
    logic       match;
    logic       ptr_zero;
    logic       ptr_one;
    logic       scan_last;
    logic       clear_last;
  } stat_t;

endpackage

FILE: rtl/best_move_table_with_move_to_front.sv
// Best-move table (2^20 entries, indexed directly by table_index) with an
// on-chip move list of 256 entries and move-to-front reordering on probe hits.
// After reset the block sweeps the table once, one entry per cycle, and holds
// in_ready_o low until the sweep ends. One word is in flight at a time: clear
// and append finish straight after decode; a store reads the list and the
// table and then writes the table if the stored depth allows, unless its list
// index is out of range; a probe reads the table and, on a hit with a non-empty
// list, searches the list one entry per cycle, and on a match at position j > 0
// shifts the entries before j back one per cycle, using the list's one read
// port and one write port, then writes the move to the front. A finished result
// waits in the output register while the next word is taken.
module best_move_table_with_move_to_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bmt_pkg::req_t in_word_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bmt_pkg::rsp_t out_word_o
);

  bmt_pkg::cmd_t  cmd;
  bmt_pkg::stat_t stat;

  bmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bmt_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_word_o (out_word_o)
  );

endmodule

FILE: rtl/bmt_dp.sv
module bmt_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bmt_pkg::req_t   in_word_i,
  input  bmt_pkg::cmd_t   cmd_i,
  output bmt_pkg::stat_t  stat_o,
  output bmt_pkg::rsp_t   out_word_o
);

  localparam int unsigned TableAw = bmt_pkg::TABLE_AW;
  localparam int unsigned ListAw  = bmt_pkg::LIST_AW;
  localparam int unsigned ListCw  = bmt_pkg::LIST_CW;
  localparam int unsigned SqW     = bmt_pkg::SQ_W;

  bmt_pkg::entry_t tbl_mem [bmt_pkg::TABLE_ENTRIES];
  logic [2*SqW-1:0] list_mem [bmt_pkg::LIST_ENTRIES];

  bmt_pkg::req_t    req_q;
  bmt_pkg::entry_t  tab_rd_q;
  logic [2*SqW-1:0] list_rd_q;
  logic [SqW-1:0]   ff_q, ft_q;
  logic [ListAw-1:0] ptr_q, ptr_d;
  logic [ListCw-1:0] count_q, count_d;
  logic [TableAw-1:0] clr_addr_q, clr_addr_d;
  bmt_pkg::rsp_t    out_q;

  logic [TableAw-1:0] tab_addr;
  logic [ListAw-1:0]  list_ra, list_wa;
  logic               list_re, list_we;
  logic [2*SqW-1:0]   list_wd, app_pair;
  logic               tab_we;
  bmt_pkg::entry_t    tab_wd;
  logic               hit;

  assign tab_addr = req_q.table_index[TableAw-1:0];
  assign app_pair = {req_q.move_word[bmt_pkg::FROM_LSB +: SqW],
                     req_q.move_word[bmt_pkg::TO_LSB +: SqW]};

  always_comb begin
    list_re = 1'b0;
    list_ra = '0;
    list_we = 1'b0;
    list_wa = '0;
    list_wd = list_rd_q;
    ptr_d   = ptr_q;
    count_d = count_q;
    case (cmd_i.list_op)
      bmt_pkg::LOP_STORE_RD: begin
        list_re = 1'b1;
        list_ra = req_q.move_index[ListAw-1:0];
      end
      bmt_pkg::LOP_SCAN_FIRST: begin
        list_re = 1'b1;
        list_ra = '0;
        ptr_d   = '0;
      end
      bmt_pkg::LOP_SCAN_NEXT: begin
        list_re = 1'b1;
        list_ra = ptr_q + ListAw'(1);
        ptr_d   = ptr_q + ListAw'(1);
      end
      bmt_pkg::LOP_SHIFT_START: begin
        list_re = 1'b1;
        list_ra = ptr_q - ListAw'(1);
      end
      bmt_pkg::LOP_SHIFT_STEP: begin
        list_re = 1'b1;
        list_ra = ptr_q - ListAw'(2);
        list_we = 1'b1;
        list_wa = ptr_q;
        list_wd = list_rd_q;
        ptr_d   = ptr_q - ListAw'(1);
      end
      bmt_pkg::LOP_FRONT: begin
        list_we = 1'b1;
        list_wa = '0;
        list_wd = {ff_q, ft_q};
      end
      bmt_pkg::LOP_APPEND: begin
        list_we = 1'b1;
        list_wa = count_q[ListAw-1:0];
        list_wd = app_pair;
        count_d = count_q + ListCw'(1);
      end
      bmt_pkg::LOP_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    tab_we     = 1'b0;
    tab_wd     = '0;
    clr_addr_d = clr_addr_q;
    case (cmd_i.tab_op)
      bmt_pkg::TOP_WR: begin
        tab_we         = 1'b1;
        tab_wd.valid   = 1'b1;
        tab_wd.depth   = req_q.search_depth;
        tab_wd.from_sq = list_rd_q[2*SqW-1:SqW];
        tab_wd.to_sq   = list_rd_q[SqW-1:0];
      end
      bmt_pkg::TOP_CLR: begin
        clr_addr_d = clr_addr_q + TableAw'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tab_op == bmt_pkg::TOP_CLR) begin
      tbl_mem[clr_addr_q] <= '0;
    end else if (tab_we) begin
      tbl_mem[tab_addr] <= tab_wd;
    end
    if (cmd_i.tab_op == bmt_pkg::TOP_RD) begin
      tab_rd_q <= tbl_mem[tab_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_mem[list_wa] <= list_wd;
    end
    if (list_re) begin
      list_rd_q <= list_mem[list_ra];
    end
  end

  assign hit = (cmd_i.out_status == bmt_pkg::ST_HIT_ABSENT) ||
               (cmd_i.out_status == bmt_pkg::ST_HIT_FRONT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_word_i;
    end
    if (cmd_i.latch_entry) begin
      ff_q <= tab_rd_q.from_sq;
      ft_q <= tab_rd_q.to_sq;
    end
    if (cmd_i.load_out) begin
      out_q.status      <= cmd_i.out_status;
      out_q.found_from  <= hit ? ff_q : '0;
      out_q.found_to    <= hit ? ft_q : '0;
      out_q.list_length <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      count_q    <= '0;
      clr_addr_q <= '0;
    end else begin
      ptr_q      <= ptr_d;
      count_q    <= count_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_comb begin
    stat_o.req_type   = req_q.req_type;
    stat_o.bound_bad  = {1'b0, req_q.move_index} >= count_q;
    stat_o.tab_valid  = tab_rd_q.valid;
    stat_o.depth_ok   = tab_rd_q.depth >= req_q.search_depth;
    stat_o.list_full  = count_q == ListCw'(bmt_pkg::LIST_ENTRIES);
    stat_o.list_empty = count_q == '0;
    stat_o.match      = list_rd_q == {ff_q, ft_q};
    stat_o.ptr_zero   = ptr_q == '0;
    stat_o.ptr_one    = ptr_q == ListAw'(1);
    stat_o.scan_last  = ({1'b0, ptr_q} + ListCw'(1)) == count_q;
    stat_o.clear_last = clr_addr_q == '1;
  end

  assign out_word_o = out_q;

endmodule

FILE: rtl/bmt_ctrl.sv
module bmt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  bmt_pkg::stat_t stat_i,
  output bmt_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_STORE,
    S_PROBE,
    S_SCAN,
    S_SHIFT,
    S_FRONT,
    S_FINISH
  } state_e;

  state_e            state_q, state_d;
  bmt_pkg::status_e  status_q, status_d;
  logic              out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    cmd_o.out_status = status_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.tab_op = bmt_pkg::TOP_CLR;
        if (stat_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.req_type)
          bmt_pkg::REQ_STORE: begin
            if (stat_i.bound_bad) begin
              status_d = bmt_pkg::ST_CLEAR_OR_BAD;
              state_d  = S_FINISH;
            end else begin
              cmd_o.tab_op  = bmt_pkg::TOP_RD;
              cmd_o.list_op = bmt_pkg::LOP_STORE_RD;
              state_d       = S_STORE;
            end
          end
          bmt_pkg::REQ_PROBE: begin
            cmd_o.tab_op = bmt_pkg::TOP_RD;
            state_d      = S_PROBE;
          end
          bmt_pkg::REQ_APPEND: begin
            if (stat_i.list_full) begin
              status_d = bmt_pkg::ST_FULL;
            end else begin
              cmd_o.list_op = bmt_pkg::LOP_APPEND;
              status_d      = bmt_pkg::ST_APPENDED;
            end
            state_d = S_FINISH;
          end
          default: begin
            cmd_o.list_op = bmt_pkg::LOP_CLEAR;
            status_d      = bmt_pkg::ST_CLEAR_OR_BAD;
            state_d       = S_FINISH;
          end
        endcase
      end
      S_STORE: begin
        if (!stat_i.tab_valid || stat_i.depth_ok) begin
          cmd_o.tab_op = bmt_pkg::TOP_WR;
          status_d     = bmt_pkg::ST_STORED;
        end else begin
          status_d = bmt_pkg::ST_SKIPPED;
        end
        state_d = S_FINISH;
      end
      S_PROBE: begin
        if (!stat_i.tab_valid) begin
          status_d = bmt_pkg::ST_MISS;
          state_d  = S_FINISH;
        end else begin
          cmd_o.latch_entry = 1'b1;
          if (stat_i.list_empty) begin
            status_d = bmt_pkg::ST_HIT_ABSENT;
            state_d  = S_FINISH;
          end else begin
            cmd_o.list_op = bmt_pkg::LOP_SCAN_FIRST;
            state_d       = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat_i.match) begin
          if (stat_i.ptr_zero) begin
            status_d = bmt_pkg::ST_HIT_FRONT;
            state_d  = S_FINISH;
          end else begin
            cmd_o.list_op = bmt_pkg::LOP_SHIFT_START;
            state_d       = S_SHIFT;
          end
        end else if (stat_i.scan_last) begin
          status_d = bmt_pkg::ST_HIT_ABSENT;
          state_d  = S_FINISH;
        end else begin
          cmd_o.list_op = bmt_pkg::LOP_SCAN_NEXT;
        end
      end
      S_SHIFT: begin
        cmd_o.list_op = bmt_pkg::LOP_SHIFT_STEP;
        if (stat_i.ptr_one) begin
          state_d = S_FRONT;
        end
      end
      S_FRONT: begin
        cmd_o.list_op = bmt_pkg::LOP_FRONT;
        status_d      = bmt_pkg::ST_HIT_FRONT;
        state_d       = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      status_q    <= bmt_pkg::ST_STORED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule
